@@ src/vsrc_pkg.sv @@
package vsrc_pkg;

    localparam int CHAR_BITS      = 8;
    localparam int FIELD_BITS     = 16;
    localparam int BOUND_BITS     = 3 * FIELD_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = BOUND_BITS;

    typedef logic [CHAR_BITS-1:0]      char_t;
    typedef logic [FIELD_BITS-1:0]     field_t;
    typedef logic [BOUND_BITS-1:0]     bound_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam cfg_index_t REG_LOWER_ENABLE = 2'd0;
    localparam cfg_index_t REG_LOWER_BOUND  = 2'd1;
    localparam cfg_index_t REG_UPPER_ENABLE = 2'd2;
    localparam cfg_index_t REG_UPPER_BOUND  = 2'd3;

    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_NINE = 8'h39;
    localparam char_t CHAR_DOT  = 8'h2e;

    localparam logic [1:0] PART_MAJOR = 2'd0;
    localparam logic [1:0] PART_MINOR = 2'd1;
    localparam logic [1:0] PART_PATCH = 2'd2;

endpackage

@@ src/vsrc_if.sv @@
interface vsrc_char_if;
    logic                  valid;
    logic                  ready;
    vsrc_pkg::char_t       char_code;
    logic                  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface vsrc_result_if;
    logic                  valid;
    logic                  ready;
    logic                  parse_ok;
    vsrc_pkg::field_t      major_value;
    vsrc_pkg::field_t      minor_value;
    vsrc_pkg::field_t      patch_value;
    logic                  in_range;

    modport source (output valid, output parse_ok, output major_value, output minor_value,
                    output patch_value, output in_range, input ready);
    modport sink   (input valid, input parse_ok, input major_value, input minor_value,
                    input patch_value, input in_range, output ready);
endinterface

interface vsrc_cfg_if;
    logic                  valid;
    logic                  ready;
    vsrc_pkg::cfg_index_t  index;
    vsrc_pkg::cfg_data_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/version_string_range_check.sv @@
// Version string range check.
// chars: one beat per character of a MAJOR[.MINOR[.PATCH]] string, last_char set on
//   the final beat. Non-final beats produce no result.
// results: one beat per string, carrying parse_ok, the parsed triplet and in_range
//   against the enabled lower (inclusive) and upper (exclusive) bounds.
// cfg: register writes (0 lower_enable, 1 lower_bound, 2 upper_enable, 3 upper_bound),
//   always ready; write only while no string is in flight.
// Path: the last character enters the input register, then is parsed and compared
//   into the result register; a stalled result register can hold it in between.
// Throughput: one character per cycle; a last character waits while the result
//   register stalls. Multiply-by-ten and add on the part accumulator are combinational.
// Reset clears the parse state, the bounds and both pipeline valid bits.
// A stalled receiver holds the result register; characters that produce no result
//   keep flowing, and a last character waits in the input register until the result
//   register frees, which in turn stalls chars.
module version_string_range_check #(
    parameter int PART_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    vsrc_char_if.sink              chars,
    vsrc_result_if.source          results,
    vsrc_cfg_if.sink               cfg
);

    localparam int CMP_BITS  = (PART_BITS > vsrc_pkg::FIELD_BITS) ? PART_BITS
                                                                  : vsrc_pkg::FIELD_BITS;
    localparam int PROD_BITS = PART_BITS + 4;

    typedef logic [PART_BITS-1:0]  part_t;
    typedef logic [CMP_BITS-1:0]   cmp_t;

    logic               lower_enable_reg;
    logic               upper_enable_reg;
    vsrc_pkg::bound_t   lower_bound_reg;
    vsrc_pkg::bound_t   upper_bound_reg;

    logic               s1_vld_reg;
    vsrc_pkg::char_t    s1_char_reg;
    logic               s1_last_reg;

    logic [1:0]         part_index_reg, part_index_next;
    part_t              acc_reg, acc_next;
    logic               seen_reg, seen_next;
    logic               err_reg, err_next;
    part_t              major_reg, major_next;
    part_t              minor_reg, minor_next;

    logic               out_vld_reg;
    logic               ok_reg, ok_next;
    vsrc_pkg::field_t   maj_out_reg, maj_out_next;
    vsrc_pkg::field_t   min_out_reg, min_out_next;
    vsrc_pkg::field_t   pat_out_reg, pat_out_next;
    logic               inr_reg, inr_next;

    logic               proceed;
    logic               fire;
    logic               is_digit;
    logic [3:0]         digit;
    logic [PROD_BITS-1:0] prod;
    logic               overflow;
    part_t              v_maj, v_min, v_pat;
    logic [3*CMP_BITS-1:0] v_cmp, lb_cmp, ub_cmp;

    assign proceed      = !s1_last_reg || !out_vld_reg || results.ready;
    assign fire         = s1_vld_reg && proceed;
    assign chars.ready  = !s1_vld_reg || proceed;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_enable_reg <= 1'b0;
            upper_enable_reg <= 1'b0;
            lower_bound_reg  <= '0;
            upper_bound_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                vsrc_pkg::REG_LOWER_ENABLE: lower_enable_reg <= cfg.data[0];
                vsrc_pkg::REG_LOWER_BOUND:  lower_bound_reg  <= cfg.data;
                vsrc_pkg::REG_UPPER_ENABLE: upper_enable_reg <= cfg.data[0];
                vsrc_pkg::REG_UPPER_BOUND:  upper_bound_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            s1_vld_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            s1_char_reg <= chars.char_code;
            s1_last_reg <= chars.last_char;
        end
    end

    always_comb
    begin
        is_digit = s1_char_reg inside {[vsrc_pkg::CHAR_ZERO:vsrc_pkg::CHAR_NINE]};
        digit    = 4'(s1_char_reg - vsrc_pkg::CHAR_ZERO);
        prod     = (PROD_BITS'(acc_reg) << 3) + (PROD_BITS'(acc_reg) << 1)
                   + PROD_BITS'(digit);
        overflow = |prod[PROD_BITS-1:PART_BITS];

        part_index_next = part_index_reg;
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;

        if (!err_reg)
        begin
            if (is_digit)
            begin
                if (overflow)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    acc_next  = prod[PART_BITS-1:0];
                    seen_next = 1'b1;
                end
            end
            else if (s1_char_reg == vsrc_pkg::CHAR_DOT)
            begin
                if (!seen_reg || part_index_reg == vsrc_pkg::PART_PATCH
                    || part_index_reg == 2'd3 || s1_last_reg)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    if (part_index_reg == vsrc_pkg::PART_MAJOR)
                    begin
                        major_next = acc_reg;
                    end
                    else
                    begin
                        minor_next = acc_reg;
                    end
                    part_index_next = part_index_reg + 2'd1;
                    acc_next        = '0;
                    seen_next       = 1'b0;
                end
            end
            else
            begin
                err_next = 1'b1;
            end
        end

        ok_next = !err_next && seen_next;
        v_maj   = '0;
        v_min   = '0;
        v_pat   = '0;
        if (ok_next)
        begin
            case (part_index_next)
                vsrc_pkg::PART_MAJOR:
                begin
                    v_maj = acc_next;
                end
                vsrc_pkg::PART_MINOR:
                begin
                    v_maj = major_next;
                    v_min = acc_next;
                end
                default:
                begin
                    v_maj = major_next;
                    v_min = minor_next;
                    v_pat = acc_next;
                end
            endcase
        end

        v_cmp  = {CMP_BITS'(v_maj), CMP_BITS'(v_min), CMP_BITS'(v_pat)};
        lb_cmp = {CMP_BITS'(lower_bound_reg[47:32]), CMP_BITS'(lower_bound_reg[31:16]),
                  CMP_BITS'(lower_bound_reg[15:0])};
        ub_cmp = {CMP_BITS'(upper_bound_reg[47:32]), CMP_BITS'(upper_bound_reg[31:16]),
                  CMP_BITS'(upper_bound_reg[15:0])};

        inr_next = ok_next
                   && (!lower_enable_reg || v_cmp >= lb_cmp)
                   && (!upper_enable_reg || v_cmp <  ub_cmp);

        maj_out_next = vsrc_pkg::field_t'(cmp_t'(v_maj));
        min_out_next = vsrc_pkg::field_t'(cmp_t'(v_min));
        pat_out_next = vsrc_pkg::field_t'(cmp_t'(v_pat));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_index_reg <= vsrc_pkg::PART_MAJOR;
            acc_reg        <= '0;
            seen_reg       <= 1'b0;
            err_reg        <= 1'b0;
            major_reg      <= '0;
            minor_reg      <= '0;
        end
        else if (fire)
        begin
            if (s1_last_reg)
            begin
                part_index_reg <= vsrc_pkg::PART_MAJOR;
                acc_reg        <= '0;
                seen_reg       <= 1'b0;
                err_reg        <= 1'b0;
                major_reg      <= '0;
                minor_reg      <= '0;
            end
            else
            begin
                part_index_reg <= part_index_next;
                acc_reg        <= acc_next;
                seen_reg       <= seen_next;
                err_reg        <= err_next;
                major_reg      <= major_next;
                minor_reg      <= minor_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && s1_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s1_last_reg)
        begin
            ok_reg      <= ok_next;
            maj_out_reg <= maj_out_next;
            min_out_reg <= min_out_next;
            pat_out_reg <= pat_out_next;
            inr_reg     <= inr_next;
        end
    end

    assign results.valid       = out_vld_reg;
    assign results.parse_ok    = ok_reg;
    assign results.major_value = maj_out_reg;
    assign results.minor_value = min_out_reg;
    assign results.patch_value = pat_out_reg;
    assign results.in_range    = inr_reg;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int PART_BITS   = 16;
    localparam int PART_LIMIT  = (1 << PART_BITS) - 1;
    localparam int PHASES      = 9;
    localparam int PHASE_CHARS = 180;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic             parse_ok;
        vsrc_pkg::field_t major;
        vsrc_pkg::field_t minor;
        vsrc_pkg::field_t patch;
        logic             in_range;
    } version_result_t;

    class semver_predictor;
        logic              lower_on;
        vsrc_pkg::bound_t  lower_limit;
        logic              upper_on;
        vsrc_pkg::bound_t  upper_limit;
        logic [1:0]        part_sel;
        int unsigned       part_acc;
        logic              have_digit;
        logic              broken;
        int unsigned       major_keep;
        int unsigned       minor_keep;
        version_result_t   pending_triplets[$];
        int                mismatches;

        function new();
            lower_on    = 1'b0;
            lower_limit = '0;
            upper_on    = 1'b0;
            upper_limit = '0;
            mismatches  = 0;
            clear_string();
        endfunction

        function void clear_string();
            part_sel   = vsrc_pkg::PART_MAJOR;
            part_acc   = 0;
            have_digit = 1'b0;
            broken     = 1'b0;
            major_keep = 0;
            minor_keep = 0;
        endfunction

        function void write_reg(vsrc_pkg::cfg_index_t idx, vsrc_pkg::cfg_data_t data);
            case (idx)
                vsrc_pkg::REG_LOWER_ENABLE: lower_on    = data[0];
                vsrc_pkg::REG_LOWER_BOUND:  lower_limit = vsrc_pkg::bound_t'(data);
                vsrc_pkg::REG_UPPER_ENABLE: upper_on    = data[0];
                vsrc_pkg::REG_UPPER_BOUND:  upper_limit = vsrc_pkg::bound_t'(data);
                default: ;
            endcase
        endfunction

        function void note_char(vsrc_pkg::char_t c, logic last);
            int unsigned      grown;
            version_result_t  r;
            vsrc_pkg::bound_t triplet;
            if (!broken)
            begin
                if (c >= vsrc_pkg::CHAR_ZERO && c <= vsrc_pkg::CHAR_NINE)
                begin
                    grown = part_acc * 10 + (32'(c) - 32'(vsrc_pkg::CHAR_ZERO));
                    if (grown > PART_LIMIT)
                    begin
                        broken = 1'b1;
                    end
                    else
                    begin
                        part_acc   = grown;
                        have_digit = 1'b1;
                    end
                end
                else if (c == vsrc_pkg::CHAR_DOT)
                begin
                    if (!have_digit || part_sel == vsrc_pkg::PART_PATCH || last)
                    begin
                        broken = 1'b1;
                    end
                    else
                    begin
                        if (part_sel == vsrc_pkg::PART_MAJOR)
                            major_keep = part_acc;
                        else
                            minor_keep = part_acc;
                        part_sel   = part_sel + 2'd1;
                        part_acc   = 0;
                        have_digit = 1'b0;
                    end
                end
                else
                begin
                    broken = 1'b1;
                end
            end
            if (last)
            begin
                r.parse_ok = !broken && have_digit;
                r.major    = '0;
                r.minor    = '0;
                r.patch    = '0;
                if (r.parse_ok)
                begin
                    case (part_sel)
                        vsrc_pkg::PART_MAJOR: r.major = vsrc_pkg::field_t'(part_acc);
                        vsrc_pkg::PART_MINOR:
                        begin
                            r.major = vsrc_pkg::field_t'(major_keep);
                            r.minor = vsrc_pkg::field_t'(part_acc);
                        end
                        default:
                        begin
                            r.major = vsrc_pkg::field_t'(major_keep);
                            r.minor = vsrc_pkg::field_t'(minor_keep);
                            r.patch = vsrc_pkg::field_t'(part_acc);
                        end
                    endcase
                end
                triplet    = {r.major, r.minor, r.patch};
                r.in_range = r.parse_ok
                             && (!lower_on || triplet >= lower_limit)
                             && (!upper_on || triplet < upper_limit);
                pending_triplets.push_back(r);
                clear_string();
            end
        endfunction

        function void compare_field(string name, vsrc_pkg::field_t want,
                                    vsrc_pkg::field_t got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic ok, vsrc_pkg::field_t maj, vsrc_pkg::field_t min,
                                   vsrc_pkg::field_t pat, logic inr);
            version_result_t e;
            if (pending_triplets.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
                return;
            end
            e = pending_triplets.pop_front();
            compare_field("parse_ok", vsrc_pkg::field_t'(e.parse_ok), vsrc_pkg::field_t'(ok));
            compare_field("major_value", e.major, maj);
            compare_field("minor_value", e.minor, min);
            compare_field("patch_value", e.patch, pat);
            compare_field("in_range", vsrc_pkg::field_t'(e.in_range), vsrc_pkg::field_t'(inr));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    vsrc_char_if   char_ch();
    vsrc_result_if result_ch();
    vsrc_cfg_if    cfg_ch();

    version_string_range_check #(.PART_BITS(PART_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (char_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    semver_predictor  semver;
    vsrc_pkg::char_t  text_buf[$];
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_seq;
    int               chars_sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && result_ch.valid && result_ch.ready)
            semver.check_result(result_ch.parse_ok, result_ch.major_value,
                                result_ch.minor_value, result_ch.patch_value,
                                result_ch.in_range);

    task automatic send_char(vsrc_pkg::char_t c, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last_char <= last;
        @(posedge clk);
        while (!char_ch.ready) @(posedge clk);
        semver.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(vsrc_pkg::char_t'(s[i]));
        send_string();
    endtask

    task automatic write_reg(vsrc_pkg::cfg_index_t idx, vsrc_pkg::cfg_data_t data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        semver.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        char_ch.valid <= 1'b0;
        while (semver.pending_triplets.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int unsigned pick_part();
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: return $urandom_range(3);
            8, 9:                   return 0;
            10, 11:                 return PART_LIMIT;
            12, 13, 14:             return $urandom_range(PART_LIMIT);
            15:                     return PART_LIMIT + 1 + $urandom_range(40000);
            default:                return $urandom_range(99);
        endcase
    endfunction

    function automatic void push_number(int unsigned value);
        vsrc_pkg::char_t digits[$];
        int unsigned     v;
        v = value;
        do
        begin
            digits.push_front(vsrc_pkg::char_t'(vsrc_pkg::CHAR_ZERO + v % 10));
            v = v / 10;
        end
        while (v != 0);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) text_buf.push_back(vsrc_pkg::CHAR_ZERO);
        foreach (digits[i])
            text_buf.push_back(digits[i]);
    endfunction

    function automatic void build_string();
        int kind;
        int parts;
        kind = $urandom_range(99);
        text_buf.delete();
        if (kind < 15)
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(4))
                    0, 1:
                        text_buf.push_back(
                            vsrc_pkg::char_t'(vsrc_pkg::CHAR_ZERO + $urandom_range(9)));
                    2:       text_buf.push_back(vsrc_pkg::CHAR_DOT);
                    default: text_buf.push_back(vsrc_pkg::char_t'($urandom_range(255)));
                endcase
            end
            return;
        end
        parts = (kind < 85) ? $urandom_range(1, 3) : 3;
        for (int k = 0; k < parts; k++)
        begin
            if (k > 0)
                text_buf.push_back(vsrc_pkg::CHAR_DOT);
            push_number(pick_part());
        end
        if (kind >= 85)
        begin
            // alter a well-formed string in one place, which usually breaks it
            case ($urandom_range(3))
                0:
                begin
                    text_buf.push_back(vsrc_pkg::CHAR_DOT);
                    push_number(pick_part());
                end
                1:       text_buf.push_back(vsrc_pkg::CHAR_DOT);
                2:       text_buf[$urandom_range(text_buf.size() - 1)] = vsrc_pkg::CHAR_DOT;
                default: text_buf[$urandom_range(text_buf.size() - 1)] =
                             vsrc_pkg::char_t'($urandom_range(255));
            endcase
        end
    endfunction

    function automatic vsrc_pkg::bound_t small_bound();
        return {16'($urandom_range(3)), 16'($urandom_range(3)), 16'($urandom_range(3))};
    endfunction

    task automatic apply_setting(int phase);
        vsrc_pkg::bound_t lo;
        vsrc_pkg::bound_t hi;
        logic             lo_on;
        logic             hi_on;
        lo    = small_bound();
        hi    = small_bound();
        lo_on = 1'b1;
        hi_on = 1'b1;
        case (phase)
            0:
            begin
                lo_on = 1'b0;
                hi_on = 1'b0;
                lo    = '0;
                hi    = '0;
            end
            1:
            begin
                lo = '0;
                hi = '1;
            end
            2:
            begin
                lo    = '1;
                hi_on = 1'b0;
            end
            3:
            begin
                lo_on = 1'b0;
                hi    = '0;
            end
            // exact match
            5: hi = {lo[47:16], lo[15:0] + 16'd1};
            6:
            begin
                lo = vsrc_pkg::bound_t'({$urandom, $urandom});
                hi = vsrc_pkg::bound_t'({$urandom, $urandom});
            end
            7: hi_on = 1'b0;
            8:
            begin
                lo_on = 1'($urandom_range(1));
                hi_on = 1'($urandom_range(1));
            end
            default: ;
        endcase
        write_reg(vsrc_pkg::REG_LOWER_ENABLE, vsrc_pkg::cfg_data_t'(lo_on));
        write_reg(vsrc_pkg::REG_LOWER_BOUND, vsrc_pkg::cfg_data_t'(lo));
        write_reg(vsrc_pkg::REG_UPPER_ENABLE, vsrc_pkg::cfg_data_t'(hi_on));
        write_reg(vsrc_pkg::REG_UPPER_BOUND, vsrc_pkg::cfg_data_t'(hi));
    endtask

    initial
    begin
        int phase_start;
        rst_n             <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= '0;
        char_ch.last_char <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= vsrc_pkg::REG_LOWER_ENABLE;
        cfg_ch.data       <= '0;
        send_idle_pct = 32;
        recv_idle_pct = 80;
        hold_seq      = 0;
        chars_sent    = 0;
        semver        = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("0");
        send_text("65535");
        send_text("1.2.3");
        send_text("1.");
        send_text(".5");
        send_text("1.2.3.4");
        send_text("70000");
        text_buf.delete();
        text_buf.push_back(8'hff);
        send_string();
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            apply_setting(phase);
            send_idle_pct = (phase < 3) ? 32 : ((phase < 6) ? 80 : 0);
            recv_idle_pct = (phase < 3) ? 80 : ((phase < 6) ? 32 : 0);
            // hold results off so the input backs up
            if (phase == 6)
                hold_seq++;
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS)
            begin
                build_string();
                send_string();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (semver.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
src/vsrc_pkg.sv
src/vsrc_if.sv
src/version_string_range_check.sv
test/tb_top.sv
